[design/tspe_pkg.sv]
package tspe_pkg;

    localparam int PITCH_W        = 24;
    localparam int LEN_W          = 20;
    localparam int ACC_W          = 32;
    localparam int FRAC_SHIFT     = ACC_W - PITCH_W;
    localparam int DIGIT_W        = 8;
    localparam int DIGITS         = ACC_W / DIGIT_W;
    localparam int DIG_CNT_W      = $clog2(DIGITS);
    localparam int DIV_W          = 32;
    localparam int DIV_CNT_W      = $clog2(DIV_W);
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;
    localparam int COUNT_BITS_DEF = 20;

    typedef logic signed [PITCH_W-1:0] pitch_t;
    typedef logic [LEN_W-1:0]          len_t;
    typedef logic signed [ACC_W-1:0]   acc_t;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND = 2'd3;

    // defaults: 75.0, 48.0 semitones, 441 and 6615 samples; power-up note 24.0
    localparam pitch_t START_RST  = 24'sd4915200;
    localparam pitch_t MID_RST    = 24'sd3145728;
    localparam len_t   FIRST_RST  = 20'd441;
    localparam len_t   SECOND_RST = 20'd6615;
    localparam pitch_t NOTE_RST   = 24'sd1572864;

    localparam acc_t ACC_MAX = 32'sh7FFF_FFFF;
    localparam acc_t ACC_MIN = 32'sh8000_0000;

endpackage

[design/tspe_if.sv]
interface tspe_in_if;
    import tspe_pkg::*;

    logic   valid;
    logic   ready;
    logic   kind;
    pitch_t note_pitch;

    modport source (output valid, output kind, output note_pitch, input ready);
    modport sink   (input valid, input kind, input note_pitch, output ready);
endinterface

interface tspe_out_if;
    import tspe_pkg::*;

    logic   valid;
    logic   ready;
    pitch_t pitch;

    modport source (output valid, output pitch, input ready);
    modport sink   (input valid, input pitch, output ready);
endinterface

[design/tspe_div.sv]
// Unsigned restoring divider, one quotient bit per cycle.
module tspe_div #(
    parameter int DVS_W = tspe_pkg::COUNT_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tspe_pkg::DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0]           divisor,
    output logic                       done,
    output logic [tspe_pkg::DIV_W-1:0] quotient
);
    import tspe_pkg::*;

    logic [DVS_W:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]   quo_reg, quo_next;
    logic [DVS_W-1:0]   dvs_reg, dvs_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic [DVS_W:0]     trial;
    logic [DVS_W+1:0]   diff;
    logic               fits;

    always_comb
    begin
        trial = {rem_reg[DVS_W-1:0], quo_reg[DIV_W-1]};
        diff  = {1'b0, trial} - {2'b00, dvs_reg};
        fits  = !diff[DVS_W+1];

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DVS_W:0] : trial;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[design/two_segment_pitch_envelope.sv]
// Two-segment linear pitch envelope for percussion voices.
// cmd: one beat per item. kind 0 is a sample tick, kind 1 a trigger that
//   restarts the envelope at start_pitch and ramps to mid_pitch over
//   first_length ticks, then to note_pitch over second_length ticks.
// env: one beat per tick with the pitch after that tick; a trigger gives none.
// cfg_we/cfg_index/cfg_data write the four registers; new values take effect
//   at the next trigger.
// A tick passes four 8-bit digits through the serial accumulator adder, then
//   saturation and the segment counter; once the envelope is done a tick skips
//   the adder.
// A trigger waits for the two bit-serial 32-step increment dividers, which
//   run side by side.
// One item is in work at a time; cmd.ready rises again as soon as the result
//   sits in the output register, so the next item may start while env stalls.
//   The block only waits if a new result is ready while the old one is unread.
// After reset the block runs a trigger with the default registers and note
//   24.0 (cmd.ready low meanwhile) and then waits for items.
module two_segment_pitch_envelope #(
    parameter int COUNT_BITS = tspe_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tspe_in_if.sink                         cmd,
    tspe_out_if.source                      env,
    input  logic                            cfg_we,
    input  logic [tspe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tspe_pkg::CFG_DATA_W-1:0] cfg_data
);
    import tspe_pkg::*;

    localparam int EXT_W = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
    localparam logic [EXT_W-1:0] CNT_MAX = EXT_W'((64'd1 << COUNT_BITS) - 64'd1);

    localparam logic [2:0] ST_INIT = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    localparam logic [1:0] SEG_ONE  = 2'd0;
    localparam logic [1:0] SEG_DONE = 2'd2;

    localparam logic [DIG_CNT_W-1:0] DIG_LAST = DIG_CNT_W'(DIGITS - 1);

    function automatic logic [COUNT_BITS-1:0] eff_len(input len_t l);
        logic [EXT_W-1:0] x;
        x = EXT_W'(l);
        if (x == '0)
            x = EXT_W'(1);
        else if (x > CNT_MAX)
            x = CNT_MAX;
        return COUNT_BITS'(x);
    endfunction

    function automatic acc_t step_sat(input logic [DIV_W-1:0] q, input logic neg);
        acc_t r;
        if (q[DIV_W-1])
            r = neg ? ACC_MIN : ACC_MAX;
        else
            r = neg ? acc_t'(~q + 1'b1) : acc_t'(q);
        return r;
    endfunction

    // configuration
    pitch_t start_reg, mid_reg;
    len_t   first_reg, second_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RST;
            mid_reg    <= MID_RST;
            first_reg  <= FIRST_RST;
            second_reg <= SECOND_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_START:  start_reg  <= pitch_t'(cfg_data);
                CFG_MID:    mid_reg    <= pitch_t'(cfg_data);
                CFG_FIRST:  first_reg  <= len_t'(cfg_data);
                CFG_SECOND: second_reg <= len_t'(cfg_data);
                default: ;
            endcase
        end
    end

    logic [2:0]            state_reg, state_next;
    acc_t                  level_reg, level_next;
    acc_t                  step_reg [2];
    acc_t                  step_next [2];
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [1:0]            seg_reg, seg_next;
    logic [COUNT_BITS-1:0] seg_len_reg [2];
    logic [COUNT_BITS-1:0] seg_len_next [2];
    logic [1:0]            neg_reg, neg_next;
    logic [ACC_W-1:0]      add_sh_reg, add_sh_next;
    logic                  carry_reg, carry_next;
    logic                  a_sign_reg, a_sign_next;
    logic                  b_sign_reg, b_sign_next;
    logic [DIG_CNT_W-1:0]  dig_reg, dig_next;
    logic                  adv_reg, adv_next;
    logic                  out_valid_reg, out_valid_next;
    pitch_t                out_pitch_reg, out_pitch_next;

    logic                  cmd_acc, out_free, trig;
    pitch_t                trig_note;
    logic [PITCH_W:0]      diff0, diff1, mag0, mag1;
    logic [DIV_W-1:0]      dvd0, dvd1, quo0, quo1;
    logic                  div_done0, div_done1;
    logic [DIGIT_W:0]      dsum;
    logic                  ovf;
    acc_t                  level_fin;
    logic [COUNT_BITS-1:0] cnt_inc;

    assign cmd_acc  = cmd.valid && cmd.ready;
    assign out_free = !out_valid_reg || env.ready;

    always_comb
    begin
        trig_note = (state_reg == ST_INIT) ? NOTE_RST : cmd.note_pitch;
        diff0 = {mid_reg[PITCH_W-1], mid_reg} - {start_reg[PITCH_W-1], start_reg};
        diff1 = {trig_note[PITCH_W-1], trig_note} - {mid_reg[PITCH_W-1], mid_reg};
        mag0  = diff0[PITCH_W] ? (~diff0 + 1'b1) : diff0;
        mag1  = diff1[PITCH_W] ? (~diff1 + 1'b1) : diff1;
        // |diff| < 2^24, so the Q8.24 numerator fits 32 unsigned bits
        dvd0  = {mag0[PITCH_W-1:0], {FRAC_SHIFT{1'b0}}};
        dvd1  = {mag1[PITCH_W-1:0], {FRAC_SHIFT{1'b0}}};

        dsum = {1'b0, level_reg[DIGIT_W-1:0]} + {1'b0, add_sh_reg[DIGIT_W-1:0]}
             + {{DIGIT_W{1'b0}}, carry_reg};

        ovf = adv_reg && (a_sign_reg == b_sign_reg) && (level_reg[ACC_W-1] != a_sign_reg);
        if (ovf)
            level_fin = a_sign_reg ? ACC_MIN : ACC_MAX;
        else
            level_fin = level_reg;
        cnt_inc = cnt_reg + 1'b1;

        state_next      = state_reg;
        level_next      = level_reg;
        step_next[0]    = step_reg[0];
        step_next[1]    = step_reg[1];
        cnt_next        = cnt_reg;
        seg_next        = seg_reg;
        seg_len_next[0] = seg_len_reg[0];
        seg_len_next[1] = seg_len_reg[1];
        neg_next        = neg_reg;
        add_sh_next     = add_sh_reg;
        carry_next      = carry_reg;
        a_sign_next     = a_sign_reg;
        b_sign_next     = b_sign_reg;
        dig_next        = dig_reg;
        adv_next        = adv_reg;
        out_valid_next  = out_valid_reg && !env.ready;
        out_pitch_next  = out_pitch_reg;
        trig            = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                trig       = 1'b1;
                state_next = ST_DIV;
            end
            ST_IDLE:
            begin
                if (cmd_acc)
                begin
                    if (cmd.kind)
                    begin
                        trig       = 1'b1;
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        adv_next    = (seg_reg != SEG_DONE);
                        add_sh_next = step_reg[seg_reg[0]];
                        a_sign_next = level_reg[ACC_W-1];
                        b_sign_next = step_reg[seg_reg[0]][ACC_W-1];
                        carry_next  = 1'b0;
                        dig_next    = '0;
                        state_next  = (seg_reg != SEG_DONE) ? ST_ADD : ST_FIN;
                    end
                end
            end
            ST_DIV:
            begin
                if (div_done0 && div_done1)
                begin
                    step_next[0] = step_sat(quo0, neg_reg[0]);
                    step_next[1] = step_sat(quo1, neg_reg[1]);
                    state_next   = ST_IDLE;
                end
            end
            ST_ADD:
            begin
                // low digit in, level rotates right; after the last digit it is back in place
                level_next  = {dsum[DIGIT_W-1:0], level_reg[ACC_W-1:DIGIT_W]};
                add_sh_next = add_sh_reg >> DIGIT_W;
                carry_next  = dsum[DIGIT_W];
                dig_next    = dig_reg + 1'b1;
                if (dig_reg == DIG_LAST)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    level_next     = level_fin;
                    out_valid_next = 1'b1;
                    out_pitch_next = level_fin[ACC_W-1 -: PITCH_W];
                    if (adv_reg)
                    begin
                        if (cnt_inc >= seg_len_reg[seg_reg[0]])
                        begin
                            cnt_next = '0;
                            seg_next = seg_reg + 1'b1;
                        end
                        else
                            cnt_next = cnt_inc;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (trig)
        begin
            level_next      = acc_t'({start_reg, {FRAC_SHIFT{1'b0}}});
            seg_next        = SEG_ONE;
            cnt_next        = '0;
            seg_len_next[0] = eff_len(first_reg);
            seg_len_next[1] = eff_len(second_reg);
            neg_next        = {diff1[PITCH_W], diff0[PITCH_W]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            level_reg      <= acc_t'({START_RST, {FRAC_SHIFT{1'b0}}});
            cnt_reg        <= '0;
            seg_reg        <= SEG_ONE;
            seg_len_reg[0] <= COUNT_BITS'(1);
            seg_len_reg[1] <= COUNT_BITS'(1);
            dig_reg        <= '0;
            adv_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            level_reg      <= level_next;
            cnt_reg        <= cnt_next;
            seg_reg        <= seg_next;
            seg_len_reg[0] <= seg_len_next[0];
            seg_len_reg[1] <= seg_len_next[1];
            dig_reg        <= dig_next;
            adv_reg        <= adv_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg[0]   <= step_next[0];
        step_reg[1]   <= step_next[1];
        neg_reg       <= neg_next;
        add_sh_reg    <= add_sh_next;
        carry_reg     <= carry_next;
        a_sign_reg    <= a_sign_next;
        b_sign_reg    <= b_sign_next;
        out_pitch_reg <= out_pitch_next;
    end

    tspe_div #(.DVS_W(COUNT_BITS)) u_div0 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (trig),
        .dividend (dvd0),
        .divisor  (seg_len_next[0]),
        .done     (div_done0),
        .quotient (quo0)
    );

    tspe_div #(.DVS_W(COUNT_BITS)) u_div1 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (trig),
        .dividend (dvd1),
        .divisor  (seg_len_next[1]),
        .done     (div_done1),
        .quotient (quo1)
    );

    assign cmd.ready = (state_reg == ST_IDLE);
    assign env.valid = out_valid_reg;
    assign env.pitch = out_pitch_reg;

`ifndef SYNTHESIS
    a_seg_code: assert property (@(posedge clk) disable iff (!rst_n)
        seg_reg != 2'd3)
        else $error("segment index out of range");

    a_cnt_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (seg_reg != SEG_DONE) |-> (cnt_reg < seg_len_reg[seg_reg[0]]))
        else $error("sample count reached segment length");

    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        div_done0 == div_done1)
        else $error("increment dividers out of step");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result beat without a finished tick");
`endif

endmodule

[bench/tspe_envelope_checker.sv]
module tspe_envelope_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    tspe_in_if                              cmd,
    tspe_out_if                             env,
    input  logic                            cfg_we,
    input  logic [tspe_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tspe_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                              errors,
    output int                              pending
);
    import tspe_pkg::*;

    localparam int CNT_W = COUNT_BITS_DEF;

    // shadow of the register file
    pitch_t reg_start;
    pitch_t reg_mid;
    len_t   reg_first;
    len_t   reg_second;

    // envelope state
    acc_t             level;
    acc_t             step_size [2];
    logic [CNT_W-1:0] sample_count;
    logic [1:0]       segment;
    len_t             seg_len [2];

    pitch_t pitch_q [$];
    pitch_t want;

    function automatic acc_t sat_acc(input longint v);
        if (v > longint'(ACC_MAX))
            return ACC_MAX;
        if (v < longint'(ACC_MIN))
            return ACC_MIN;
        return acc_t'(v);
    endfunction

    function automatic len_t eff_len(input len_t len);
        // register is exactly CNT_W wide, so only the zero clamp can apply
        return (len == '0) ? len_t'(1) : len;
    endfunction

    // (to - from) * 256 / len, truncated toward zero, then saturated
    function automatic acc_t ramp_step(input pitch_t from, input pitch_t to, input len_t len);
        longint num;
        num = (longint'(to) - longint'(from)) * 256;
        return sat_acc(num / longint'(len));
    endfunction

    function automatic void apply_trigger(input pitch_t note);
        level        = acc_t'(longint'(reg_start) * 256);
        segment      = 2'd0;
        sample_count = '0;
        seg_len[0]   = eff_len(reg_first);
        seg_len[1]   = eff_len(reg_second);
        step_size[0] = ramp_step(reg_start, reg_mid, seg_len[0]);
        step_size[1] = ramp_step(reg_mid, note, seg_len[1]);
    endfunction

    function automatic pitch_t advance_tick();
        logic s;
        if (segment < 2'd2) begin
            s            = segment[0];
            level        = sat_acc(longint'(level) + longint'(step_size[s]));
            sample_count = sample_count + 1'b1;
            if (sample_count >= seg_len[s]) begin
                sample_count = '0;
                segment      = segment + 2'd1;
            end
        end
        // floor shift from Q8.24 to Q8.16
        return level[ACC_W-1:FRAC_SHIFT];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            reg_start  = START_RST;
            reg_mid    = MID_RST;
            reg_first  = FIRST_RST;
            reg_second = SECOND_RST;
            apply_trigger(NOTE_RST);
            pitch_q.delete();
            errors  = 0;
            pending = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_START:  reg_start  = cfg_data;
                    CFG_MID:    reg_mid    = cfg_data;
                    CFG_FIRST:  reg_first  = cfg_data[LEN_W-1:0];
                    CFG_SECOND: reg_second = cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.valid && cmd.ready) begin
                // kind set means trigger; a trigger gives no env beat
                if (cmd.kind)
                    apply_trigger(cmd.note_pitch);
                else
                    pitch_q.push_back(advance_tick());
            end
            if (env.valid && env.ready) begin
                if (pitch_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected env beat, expected none, actual pitch %0d",
                             $time, env.pitch);
                end else begin
                    want = pitch_q.pop_front();
                    if (env.pitch !== want) begin
                        errors++;
                        $display("%0t: pitch mismatch, expected %0d, actual %0d",
                                 $time, want, env.pitch);
                    end
                end
            end
            pending = pitch_q.size();
        end
    end

endmodule

[bench/tb_two_segment_pitch_envelope.sv]
module tb_two_segment_pitch_envelope;
    import tspe_pkg::*;

    localparam logic KIND_TICK     = 1'b0;
    localparam logic KIND_TRIGGER  = 1'b1;
    localparam int   SETTLE_CYCLES = 40;
    localparam int   RANDOM_ITEMS  = 1500;
    localparam int   QUIET_AFTER   = 1350;
    localparam int   MAX_TICKS     = 40;
    localparam pitch_t PITCH_MIN   = 24'sh800000;
    localparam pitch_t PITCH_MAX   = 24'sh7FFFFF;
    localparam len_t   LEN_MAX     = 20'hFFFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    bit                    quiet;
    bit                    gaps_on;
    int                    items_sent;

    tspe_in_if  cmd_if ();
    tspe_out_if env_if ();

    two_segment_pitch_envelope u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .env       (env_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tspe_envelope_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .env       (env_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // env backpressure: short stall bursts, with calm stretches toggled at random
    initial
    begin : env_stall
        int hold;
        bit calm;
        hold = 0;
        calm = 1'b0;
        env_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                calm = !calm;
            if (quiet || calm) begin
                env_if.ready = 1'b1;
                hold = 0;
            end else if (hold > 0) begin
                env_if.ready = 1'b0;
                hold--;
            end else if ($urandom_range(0, 4) == 0) begin
                env_if.ready = 1'b0;
                hold = $urandom_range(0, 2);
            end else begin
                env_if.ready = 1'b1;
            end
        end
    end

    function automatic pitch_t rand_pitch();
        case ($urandom_range(0, 7))
            0:       return PITCH_MIN;
            1:       return PITCH_MAX;
            default: return pitch_t'($urandom);
        endcase
    endfunction

    function automatic len_t rand_len();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return len_t'($urandom_range(1, LEN_MAX));
            2, 3:    return len_t'($urandom_range(13, 60));
            default: return len_t'($urandom_range(1, 12));
        endcase
    endfunction

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send(input logic kind, input pitch_t note);
        if (!quiet && gaps_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        cmd_if.valid      = 1'b1;
        cmd_if.kind       = kind;
        cmd_if.note_pitch = note;
        @(posedge clk);
        while (!cmd_if.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic ticks(input int n);
        repeat (n) send(KIND_TICK, pitch_t'($urandom));
    endtask

    // hold off until every pitch is back, then cover a trigger still in work
    task automatic drain();
        cmd_if.valid = 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge clk);
        cfg_we    = 1'b0;
        cfg_index = CFG_IDX_W'($urandom);
        cfg_data  = CFG_DATA_W'($urandom);
    endtask

    task automatic set_regs(input pitch_t start, input pitch_t mid, input len_t first,
                            input len_t second);
        drain();
        write_reg(CFG_START, start);
        write_reg(CFG_MID, mid);
        // upper data bits are don't-care for the length registers
        write_reg(CFG_FIRST, {4'($urandom), first});
        write_reg(CFG_SECOND, {4'($urandom), second});
    endtask

    initial
    begin : stimulus
        len_t first;
        len_t second;
        int   n;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        cmd_if.valid      = 1'b0;
        cmd_if.kind       = KIND_TICK;
        cmd_if.note_pitch = '0;
        quiet             = 1'b0;
        gaps_on           = 1'b1;
        items_sent        = 0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // power-up envelope with the default registers
        ticks(3);

        // saturated increments, accumulator clipping low, then holding when done
        set_regs(PITCH_MIN, PITCH_MAX, 20'd1, 20'd1);
        send(KIND_TRIGGER, PITCH_MIN);
        ticks(3);

        // zero first length behaves as one
        set_regs(PITCH_MAX, PITCH_MIN, 20'd0, 20'd2);
        send(KIND_TRIGGER, PITCH_MAX);
        ticks(4);

        // longest segments; a register write stays latent until the next trigger
        set_regs(24'sd0, PITCH_MAX, LEN_MAX, LEN_MAX);
        send(KIND_TRIGGER, 24'sd0);
        ticks(2);
        drain();
        write_reg(CFG_START, PITCH_MIN);
        ticks(2);
        send(KIND_TRIGGER, PITCH_MIN);
        ticks(2);

        while (items_sent < RANDOM_ITEMS) begin
            first   = rand_len();
            second  = rand_len();
            gaps_on = ($urandom_range(0, 3) != 0);
            set_regs(rand_pitch(), rand_pitch(), first, second);
            repeat ($urandom_range(1, 3)) begin
                if (items_sent >= QUIET_AFTER)
                    quiet = 1'b1;
                // mostly a fresh trigger; many envelopes get cut short by the next trigger
                if ($urandom_range(0, 7) != 0)
                    send(KIND_TRIGGER, rand_pitch());
                n = (first == 0 ? 1 : int'(first)) + (second == 0 ? 1 : int'(second));
                n = $urandom_range(0, n + 4);
                if (n > MAX_TICKS)
                    n = $urandom_range(MAX_TICKS / 2, MAX_TICKS);
                ticks(n);
            end
        end

        quiet = 1'b1;
        cmd_if.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/tspe_pkg.sv
design/tspe_if.sv
design/tspe_div.sv
design/two_segment_pitch_envelope.sv
bench/tspe_envelope_checker.sv
bench/tb_two_segment_pitch_envelope.sv
